### rtl/core/epi_pkg.sv
// Shared types and constants for the envelope point interpolator.
// No dependencies; imported by every module of the block.
`default_nettype none

package epi_pkg;

  // Table size default and compare width (covers 4-bit config indexes and up to 63 points)
  localparam int MAX_POINTS_DEF = 12;
  localparam int CMP_W          = 6;

  // Field widths
  localparam int POS_W  = 16;
  localparam int VAL_W  = 7;
  localparam int OUT_W  = 9;
  localparam int OP_W   = 2;
  localparam int CFGA_W = 3;
  localparam int CFGD_W = 4;

  // Divider: |(pos - p1) * (v2 - v1)| < 2^23
  localparam int NUM_W  = 23;
  localparam int PROD_W = NUM_W + 2;

  // Value limits
  localparam int VAL_MAX = 64;
  localparam logic [OUT_W-1:0] ENV_OFF_VALUE = 9'd256;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_SETPOS = 2'd2;

  // Configuration register indexes
  localparam logic [CFGA_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFGA_W-1:0] REG_ENV_FLAGS   = 3'd1;
  localparam logic [CFGA_W-1:0] REG_SUSTAIN     = 3'd2;
  localparam logic [CFGA_W-1:0] REG_LOOP_START  = 3'd3;
  localparam logic [CFGA_W-1:0] REG_LOOP_END    = 3'd4;

  // One envelope point as stored in the table
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
  } point_t;

  // Divider request and result
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [POS_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_res_t;

endpackage

`default_nettype wire

### rtl/core/epi_point_mem.sv
// Envelope point table: one write port, one read port with registered data.
// Depends on epi_pkg (point_t).
`default_nettype none

module epi_point_mem #(
  parameter int DEPTH = epi_pkg::MAX_POINTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire epi_pkg::point_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output epi_pkg::point_t      rdata
);
  import epi_pkg::*;

  point_t mem [DEPTH];
  point_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/epi_div.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on epi_pkg (div_req_t, div_res_t, NUM_W, POS_W).
`default_nettype none

module epi_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire epi_pkg::div_req_t req,
  output epi_pkg::div_res_t      res
);
  import epi_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [POS_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [POS_W-1:0] den_r;

  logic [POS_W:0]   trial;
  logic             ge;

  // trial subtract of the next dividend bit
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    ge    = (trial >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= ge ? POS_W'(trial - {1'b0, den_r}) : trial[POS_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign res.done = done_r;
  assign res.quot = quo_r;

endmodule

`default_nettype wire

### rtl/core/envelope_point_interpolator.sv
// Top level of the envelope point interpolator: config registers, sequencer, datapath.
// Depends on epi_pkg, epi_point_mem, epi_div.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in_     | in        | in_valid/in_ready   | op, key_held, point_index/pos/val, new_position
//   out_    | out       | out_valid/out_ready | envelope_value, position_after
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Point writes and set-position requests do not leave the idle state. A tick scans the point table
// from the last point down, one read of the point memory per cycle (s reads, 1..MAX_POINTS),
// then reads four more entries and runs the divider when the segment needs interpolation.
// With envelope off a tick goes straight to finish. Reset is synchronous; the point table is
// not cleared. One request is in flight at a time; a finished result waits in the output
// register and the block stalls before finishing the next tick while it is not taken.
`default_nettype none

module envelope_point_interpolator #(
  parameter int MAX_POINTS = epi_pkg::MAX_POINTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [epi_pkg::OP_W-1:0]    in_op,
  input  wire logic                        in_key_held,
  input  wire logic [3:0]                  in_point_index,
  input  wire logic [epi_pkg::POS_W-1:0]   in_point_pos,
  input  wire logic [epi_pkg::VAL_W-1:0]   in_point_val,
  input  wire logic [epi_pkg::POS_W-1:0]   in_new_position,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [epi_pkg::OUT_W-1:0]        out_envelope_value,
  output logic [epi_pkg::POS_W-1:0]        out_position_after,
  // configuration channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [epi_pkg::CFGA_W-1:0]  cfg_index,
  input  wire logic [epi_pkg::CFGD_W-1:0]  cfg_data
);
  import epi_pkg::*;

  localparam int IW    = $clog2(MAX_POINTS);
  localparam int SUM_W = PROD_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_AUX    = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  // saturate config index to the table
  function automatic logic [IW-1:0] clamp_idx(input logic [3:0] k);
    logic [CMP_W-1:0] kx;
    kx = CMP_W'(k);
    if (kx >= CMP_W'(MAX_POINTS)) begin
      return IW'(MAX_POINTS - 1);
    end
    return kx[IW-1:0];
  endfunction

  // saturate interpolated value to 0..64
  function automatic logic [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] x);
    if (x < 0) begin
      return '0;
    end
    if (x > $signed(SUM_W'(VAL_MAX))) begin
      return VAL_W'(VAL_MAX);
    end
    return x[VAL_W-1:0];
  endfunction

  // configuration registers
  logic [3:0] point_count_r;
  logic [1:0] env_flags_r;
  logic [3:0] sustain_index_r;
  logic [3:0] loop_start_index_r;
  logic [3:0] loop_end_index_r;

  // control state
  logic [2:0]       state_r, state_nxt;
  logic             out_valid_r;
  logic [POS_W-1:0] run_pos_r;

  // tick working registers
  logic [IW-1:0]    seg_r;
  logic [CMP_W-1:0] n_r;
  logic             first_r;
  logic             key_r;
  logic             off_r;
  logic             has_next_r;
  logic [1:0]       aux_r;
  logic [POS_W-1:0] p1_r, p2_r, last_pos_r, spos_r, epos_r, lspos_r;
  logic [VAL_W-1:0] v1_r, v2_r, val_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [OUT_W-1:0] out_value_r;
  logic [POS_W-1:0] out_pos_r;

  // memory and divider hookup
  logic [IW-1:0] rd_addr;
  point_t        rd_data;
  point_t        wr_data;
  logic          wr_en;
  div_req_t      div_req;
  div_res_t      div_res;

  // decoded request and combinational helpers
  logic             in_acc, tick_acc, setpos_acc, fin_load;
  logic [CMP_W-1:0] n_cfg;
  logic             found, has_next;
  logic [IW-1:0]    next_a, sus_a, lend_a, lstart_a;
  logic signed [POS_W:0]  diff_s;
  logic signed [VAL_W:0]  dv_s;
  logic             interp;
  logic signed [SUM_W-1:0] q_s, sum_s;
  logic             sus_en, loop_en, hold_cur;
  logic [POS_W-1:0] step_pos, pos_new;

  assign in_acc     = in_valid && in_ready;
  assign tick_acc   = in_acc && (in_op == OP_TICK);
  assign setpos_acc = in_acc && (in_op == OP_SETPOS);
  assign fin_load   = (state_r == S_FIN) && (!out_valid_r || out_ready);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // effective point count
  always_comb begin
    n_cfg = CMP_W'(point_count_r);
    if (n_cfg > CMP_W'(MAX_POINTS)) begin
      n_cfg = CMP_W'(MAX_POINTS);
    end
  end

  // search and auxiliary read addresses
  always_comb begin
    found    = (seg_r == '0) || (rd_data.pos <= run_pos_r);
    has_next = ((CMP_W'(seg_r) + CMP_W'(1)) < n_r);
    next_a   = has_next ? (seg_r + IW'(1)) : seg_r;
    sus_a    = clamp_idx(sustain_index_r);
    lend_a   = clamp_idx(loop_end_index_r);
    lstart_a = clamp_idx(loop_start_index_r);
  end

  // point memory
  assign wr_en = in_acc && (in_op == OP_WRITE) &&
                 (CMP_W'(in_point_index) < CMP_W'(MAX_POINTS));
  assign wr_data.pos = in_point_pos;
  assign wr_data.val = in_point_val;

  epi_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (IW'(in_point_index)),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // divider
  assign div_req.start = (state_r == S_DSTART);
  assign div_req.num   = prod_r[PROD_W-1] ? NUM_W'(-prod_r) : NUM_W'(prod_r);
  assign div_req.den   = p2_r - p1_r;

  epi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // interpolation terms
  always_comb begin
    diff_s = $signed({1'b0, run_pos_r}) - $signed({1'b0, p1_r});
    dv_s   = $signed({1'b0, v2_r}) - $signed({1'b0, v1_r});
    interp = has_next_r && (run_pos_r != p1_r) && (p2_r > p1_r);
    q_s    = $signed({2'b00, div_res.quot});
    if (prod_r[PROD_W-1]) begin
      q_s = -q_s;
    end
    sum_s  = q_s + $signed(SUM_W'(v1_r));
  end

  // position advance, sustain hold and loop jump
  always_comb begin
    sus_en   = env_flags_r[0];
    loop_en  = env_flags_r[1];
    hold_cur = key_r && sus_en && (run_pos_r == spos_r);
    step_pos = run_pos_r + POS_W'(1);
    pos_new  = run_pos_r;
    if (!off_r && (run_pos_r < last_pos_r) && !hold_cur) begin
      pos_new = step_pos;
      if (loop_en && (step_pos == epos_r) && !(key_r && sus_en && (epos_r == spos_r))) begin
        pos_new = lspos_r;
      end
    end
  end

  // sequencer next state and read address
  always_comb begin
    state_nxt = state_r;
    rd_addr   = '0;
    unique case (state_r)
      S_IDLE: begin
        rd_addr = IW'(n_cfg - CMP_W'(1));
        if (tick_acc) begin
          state_nxt = (n_cfg == '0) ? S_FIN : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (found) begin
          rd_addr   = next_a;
          state_nxt = S_AUX;
        end else begin
          rd_addr = seg_r - IW'(1);
        end
      end
      S_AUX: begin
        case (aux_r)
          2'd0:    rd_addr = sus_a;
          2'd1:    rd_addr = lend_a;
          default: rd_addr = lstart_a;
        endcase
        if (aux_r == 2'd3) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = interp ? S_DSTART : S_FIN;
      end
      S_DSTART: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_res.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      out_valid_r        <= 1'b0;
      run_pos_r          <= '0;
      point_count_r      <= '0;
      env_flags_r        <= '0;
      sustain_index_r    <= '0;
      loop_start_index_r <= '0;
      loop_end_index_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (fin_load) begin
        out_valid_r <= 1'b1;
        run_pos_r   <= pos_new;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (setpos_acc) begin
        run_pos_r <= in_new_position;
      end
      // config register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_POINT_COUNT: point_count_r      <= cfg_data;
          REG_ENV_FLAGS:   env_flags_r        <= cfg_data[1:0];
          REG_SUSTAIN:     sustain_index_r    <= cfg_data;
          REG_LOOP_START:  loop_start_index_r <= cfg_data;
          REG_LOOP_END:    loop_end_index_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // tick datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (tick_acc) begin
          n_r     <= n_cfg;
          seg_r   <= IW'(n_cfg - CMP_W'(1));
          key_r   <= in_key_held;
          off_r   <= (n_cfg == '0);
          first_r <= 1'b1;
        end
      end
      S_SEARCH: begin
        first_r <= 1'b0;
        if (first_r) begin
          last_pos_r <= rd_data.pos;
        end
        if (found) begin
          p1_r       <= rd_data.pos;
          v1_r       <= rd_data.val;
          has_next_r <= has_next;
          aux_r      <= 2'd0;
        end else begin
          seg_r <= seg_r - IW'(1);
        end
      end
      S_AUX: begin
        aux_r <= aux_r + 2'd1;
        case (aux_r)
          2'd0: begin
            p2_r <= rd_data.pos;
            v2_r <= rd_data.val;
          end
          2'd1:    spos_r  <= rd_data.pos;
          2'd2:    epos_r  <= rd_data.pos;
          default: lspos_r <= rd_data.pos;
        endcase
      end
      S_MUL: begin
        prod_r <= PROD_W'(diff_s * dv_s);
        if (!interp) begin
          val_r <= sat_val($signed(SUM_W'(v1_r)));
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          val_r <= sat_val(sum_s);
        end
      end
      S_FIN: begin
        if (fin_load) begin
          out_value_r <= off_r ? ENV_OFF_VALUE : {val_r, 2'b00};
          out_pos_r   <= pos_new;
        end
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_envelope_value = out_value_r;
  assign out_position_after = out_pos_r;

  // a result is never above 256 and always a multiple of four
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_value_r <= ENV_OFF_VALUE) && (out_value_r[1:0] == 2'b00))
    else $error("envelope value out of range");

  // finishing with a free output register publishes the result and returns to idle
  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && !out_valid_r |=> out_valid_r && (state_r == S_IDLE))
    else $error("tick did not complete");

  // running position moves only on set-position or tick completion
  a_pos_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !setpos_acc && !fin_load |=> $stable(run_pos_r))
    else $error("running position changed unexpectedly");

  // divider completes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV))
    else $error("divider done outside divide state");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for envelope_point_interpolator: directed table, then random phases.
// Depends on epi_pkg and the envelope_point_interpolator RTL; carries its own envelope predictor.
module testbench;
  import epi_pkg::*;

  localparam int MAX_PTS       = MAX_POINTS_DEF;
  localparam int MAX_GAP       = 13;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS  = 1800;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // one request as driven on the in_ channel
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             key;
    logic [3:0]       pidx;
    logic [POS_W-1:0] ppos;
    logic [VAL_W-1:0] pval;
    logic [POS_W-1:0] npos;
  } env_req_t;

  // one tick result
  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic [POS_W-1:0] pos;
  } env_result_t;

  // directed table row: a register write or a request, optionally with a fixed result
  typedef struct packed {
    logic              is_cfg;
    logic [CFGA_W-1:0] reg_idx;
    logic [CFGD_W-1:0] reg_data;
    env_req_t          req;
    logic              typed;
    env_result_t       res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, in_key_held;
  logic [OP_W-1:0]   in_op;
  logic [3:0]        in_point_index;
  logic [POS_W-1:0]  in_point_pos, in_new_position;
  logic [VAL_W-1:0]  in_point_val;
  logic out_valid, out_ready;
  logic [OUT_W-1:0]  out_envelope_value;
  logic [POS_W-1:0]  out_position_after;
  logic cfg_valid, cfg_ready;
  logic [CFGA_W-1:0] cfg_index;
  logic [CFGD_W-1:0] cfg_data;

  // predictor state and register mirror
  logic [POS_W-1:0]  tbl_pos [MAX_PTS];
  logic [VAL_W-1:0]  tbl_val [MAX_PTS];
  logic [POS_W-1:0]  run_pos;
  logic [3:0]        cfg_count, cfg_sustain, cfg_loop_start, cfg_loop_end;
  logic [1:0]        cfg_flags;

  env_result_t expected_results [$];
  dir_row_t    dir_rows [$];
  bit          calm;
  int          errors, n_requests, n_results, n_phases;

  envelope_point_interpolator u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_key_held        (in_key_held),
    .in_point_index     (in_point_index),
    .in_point_pos       (in_point_pos),
    .in_point_val       (in_point_val),
    .in_new_position    (in_new_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_envelope_value (out_envelope_value),
    .out_position_after (out_position_after),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop
  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  function automatic int clamp_point(input logic [3:0] k);
    return (int'(k) >= MAX_PTS) ? MAX_PTS - 1 : int'(k);
  endfunction

  function automatic env_req_t pack_req(input logic [OP_W-1:0] op, input logic key,
                                        input logic [3:0] pidx, input logic [POS_W-1:0] ppos,
                                        input logic [VAL_W-1:0] pval,
                                        input logic [POS_W-1:0] npos);
    return {op, key, pidx, ppos, pval, npos};
  endfunction

  function automatic dir_row_t item_row(input env_req_t req, input logic typed,
                                        input env_result_t res);
    dir_row_t row;
    row = '0;
    row.req = req;
    row.typed = typed;
    row.res = res;
    return row;
  endfunction

  function automatic dir_row_t reg_row(input logic [CFGA_W-1:0] idx,
                                       input logic [CFGD_W-1:0] data);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_data = data;
    return row;
  endfunction

  // pick a sustain/loop index: mostly inside the active points, now and then anywhere
  function automatic logic [3:0] pick_index(input int n);
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, n - 1));
  endfunction

  // envelope predictor: applies one request, returns 1 when it yields a tick result
  function automatic bit env_step(input env_req_t req, output env_result_t res);
    int n, seg, pos, val, p1, p2, v1, v2, spos, epos;
    bit held;
    res = '0;
    if (req.op == OP_WRITE) begin
      if (int'(req.pidx) < MAX_PTS) begin
        tbl_pos[req.pidx] = req.ppos;
        tbl_val[req.pidx] = req.pval;
      end
      return 1'b0;
    end
    if (req.op == OP_SETPOS) begin
      run_pos = req.npos;
      return 1'b0;
    end
    if (req.op != OP_TICK) return 1'b0;

    pos = int'(run_pos);
    n = (int'(cfg_count) > MAX_PTS) ? MAX_PTS : int'(cfg_count);
    if (n == 0) begin
      res = {ENV_OFF_VALUE, run_pos};
      return 1'b1;
    end

    // last point at or before the position, segment 0 below the first point
    seg = n - 1;
    while (seg >= 1 && int'(tbl_pos[seg]) > pos) seg--;
    val = int'(tbl_val[seg]);
    if (pos != int'(tbl_pos[seg]) && seg + 1 < n) begin
      p1 = int'(tbl_pos[seg]);
      p2 = int'(tbl_pos[seg + 1]);
      v1 = int'(tbl_val[seg]);
      v2 = int'(tbl_val[seg + 1]);
      // integer divide truncates toward zero
      if (p2 > p1) val = v1 + ((pos - p1) * (v2 - v1)) / (p2 - p1);
    end
    if (val < 0) val = 0;
    if (val > VAL_MAX) val = VAL_MAX;

    // advance, sustain hold, loop jump
    held = req.key && cfg_flags[0];
    spos = int'(tbl_pos[clamp_point(cfg_sustain)]);
    epos = int'(tbl_pos[clamp_point(cfg_loop_end)]);
    if (pos < int'(tbl_pos[n - 1]) && !(held && pos == spos)) begin
      pos++;
      if (cfg_flags[1] && pos == epos && !(held && epos == spos))
        pos = int'(tbl_pos[clamp_point(cfg_loop_start)]);
    end
    run_pos = POS_W'(pos);
    res = {OUT_W'(val * 4), run_pos};
    return 1'b1;
  endfunction

  // drive one request; entered and left on a falling edge
  task automatic send_request(input env_req_t req, input logic typed, input env_result_t res);
    int gap;
    env_result_t pred;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= req.op;
    in_key_held     <= req.key;
    in_point_index  <= req.pidx;
    in_point_pos    <= req.ppos;
    in_point_val    <= req.pval;
    in_new_position <= req.npos;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (env_step(req, pred)) expected_results.push_back(typed ? res : pred);
    if (req.op != OP_UNUSED) n_requests++;
    @(negedge clk);
  endtask

  // register write; only called while the block is idle
  task automatic write_register(input logic [CFGA_W-1:0] idx, input logic [CFGD_W-1:0] data);
    repeat ($urandom_range(1, 4)) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_POINT_COUNT: cfg_count      = data;
      REG_ENV_FLAGS:   cfg_flags      = data[1:0];
      REG_SUSTAIN:     cfg_sustain    = data;
      REG_LOOP_START:  cfg_loop_start = data;
      REG_LOOP_END:    cfg_loop_end   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop requests, wait for every result, then let a write or set-position finish
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result side: random stall before each result
  initial begin : result_ready
    int hold;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      hold = draw_gap();
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // result checker
  always @(posedge clk) begin : result_check
    env_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: envelope_value %0d position_after %0d",
               out_envelope_value, out_position_after);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_envelope_value !== want.value) begin
          $error("envelope_value: expected %0d, got %0d", want.value, out_envelope_value);
          errors++;
        end
        if (out_position_after !== want.pos) begin
          $error("position_after: expected %0d, got %0d", want.pos, out_position_after);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int k, p, v, first_p, last_p, lo, hi, n_eff, dir_done;
    logic key;
    bit in_cfg;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_TICK;
    in_key_held = 1'b0;
    in_point_index = '0;
    in_point_pos = '0;
    in_point_val = '0;
    in_new_position = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    errors = 0;
    n_requests = 0;
    n_results = 0;
    n_phases = 0;
    for (k = 0; k < MAX_PTS; k++) begin
      tbl_pos[k] = '0;
      tbl_val[k] = '0;
    end
    run_pos = '0;
    cfg_count = '0;
    cfg_flags = '0;
    cfg_sustain = '0;
    cfg_loop_start = '0;
    cfg_loop_end = '0;

    // envelope off after reset: full scale, position untouched; unused opcode changes nothing
    dir_rows.push_back(item_row(pack_req(OP_TICK, 1'b0, 4'd0, '0, '0, '0), 1'b1,
                                {ENV_OFF_VALUE, 16'd0}));
    dir_rows.push_back(item_row(pack_req(OP_SETPOS, 1'b0, 4'd0, '0, '0, 16'hFFFF), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_UNUSED, 1'b1, 4'hF, 16'hFFFF, 7'd64, 16'd0),
                                1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_TICK, 1'b1, 4'd0, '0, '0, '0), 1'b1,
                                {ENV_OFF_VALUE, 16'hFFFF}));
    // full point table, last point at the top of the range
    dir_rows.push_back(item_row(pack_req(OP_WRITE, 1'b0, 4'd0,  16'd10,    7'd40, '0), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_WRITE, 1'b0, 4'd1,  16'd20,    7'd0,  '0), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_WRITE, 1'b0, 4'd2,  16'd30,    7'd64, '0), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_WRITE, 1'b0, 4'd3,  16'd40,    7'd64, '0), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_WRITE, 1'b0, 4'd4,  16'd41,    7'd0,  '0), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_WRITE, 1'b0, 4'd5,  16'd50,    7'd33, '0), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_WRITE, 1'b0, 4'd6,  16'd60,    7'd1,  '0), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_WRITE, 1'b0, 4'd7,  16'd70,    7'd64, '0), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_WRITE, 1'b0, 4'd8,  16'd80,    7'd0,  '0), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_WRITE, 1'b0, 4'd9,  16'd100,   7'd64, '0), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_WRITE, 1'b0, 4'd10, 16'd200,   7'd17, '0), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_WRITE, 1'b0, 4'd11, 16'hFFFF,  7'd64, '0), 1'b0, '0));
    // index past the table is dropped
    dir_rows.push_back(item_row(pack_req(OP_WRITE, 1'b0, 4'hF,  16'd0,     7'd0,  '0), 1'b0, '0));
    // count and indexes above the table saturate
    dir_rows.push_back(reg_row(REG_POINT_COUNT, 4'hF));
    dir_rows.push_back(reg_row(REG_ENV_FLAGS, 4'd3));
    dir_rows.push_back(reg_row(REG_SUSTAIN, 4'hF));
    dir_rows.push_back(reg_row(REG_LOOP_START, 4'd0));
    dir_rows.push_back(reg_row(REG_LOOP_END, 4'hF));
    // before the first point: line extended backward, clipped at 64
    dir_rows.push_back(item_row(pack_req(OP_SETPOS, 1'b0, 4'd0, '0, '0, 16'd0), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_TICK, 1'b1, 4'd0, '0, '0, '0), 1'b0, '0));
    // reach the end point; loop end equals sustain point with key held, then stop at the end
    dir_rows.push_back(item_row(pack_req(OP_SETPOS, 1'b0, 4'd0, '0, '0, 16'hFFFE), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_TICK, 1'b1, 4'd0, '0, '0, '0), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_TICK, 1'b0, 4'd0, '0, '0, '0), 1'b0, '0));
    // loop only: a step that stays short of the loop end does not jump to loop start
    dir_rows.push_back(reg_row(REG_POINT_COUNT, 4'd12));
    dir_rows.push_back(reg_row(REG_ENV_FLAGS, 4'd2));
    dir_rows.push_back(reg_row(REG_SUSTAIN, 4'd0));
    dir_rows.push_back(reg_row(REG_LOOP_START, 4'd2));
    dir_rows.push_back(reg_row(REG_LOOP_END, 4'd4));
    dir_rows.push_back(item_row(pack_req(OP_SETPOS, 1'b0, 4'd0, '0, '0, 16'd39), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_TICK, 1'b0, 4'd0, '0, '0, '0), 1'b0, '0));
    // first segment with no length: the point's own value
    dir_rows.push_back(item_row(pack_req(OP_WRITE, 1'b0, 4'd1, 16'd10, 7'd0, '0), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_SETPOS, 1'b0, 4'd0, '0, '0, 16'd3), 1'b0, '0));
    dir_rows.push_back(item_row(pack_req(OP_TICK, 1'b0, 4'd0, '0, '0, '0), 1'b0, '0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    in_cfg = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        if (!in_cfg) drain_requests();
        in_cfg = 1'b1;
        write_register(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      end else begin
        in_cfg = 1'b0;
        send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
      end
    end
    dir_done = n_requests;

    // random phases: new setup, then a shaped envelope run or plain noise
    while (n_requests < dir_done + RANDOM_ITEMS) begin
      drain_requests();
      n_phases++;
      calm = ($urandom_range(0, 4) == 0);

      case ($urandom_range(0, 9))
        0:       k = 0;
        1:       k = $urandom_range(13, 15);
        2:       k = MAX_PTS;
        3:       k = 1;
        default: k = $urandom_range(2, MAX_PTS);
      endcase
      n_eff = (k == 0) ? MAX_PTS : ((k > MAX_PTS) ? MAX_PTS : k);
      write_register(REG_POINT_COUNT, CFGD_W'(k));
      write_register(REG_ENV_FLAGS, CFGD_W'($urandom_range(0, 3)));
      write_register(REG_SUSTAIN, pick_index(n_eff));
      write_register(REG_LOOP_START, pick_index(n_eff));
      write_register(REG_LOOP_END, pick_index(n_eff));

      if ($urandom_range(0, 4) == 0) begin
        // noise: any opcode, any field values
        repeat (40)
          send_request(pack_req(OP_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                4'($urandom_range(0, 15)), POS_W'($urandom),
                                VAL_W'($urandom_range(0, VAL_MAX)), POS_W'($urandom)),
                       1'b0, '0);
      end else begin
        // ascending points, a few repeated positions, low or high in the range
        p = ($urandom_range(0, 7) == 0) ? int'($urandom_range(65400, 65520))
                                        : int'($urandom_range(0, 20));
        first_p = p;
        last_p = p;
        for (k = 0; k < MAX_PTS; k++) begin
          case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = VAL_MAX;
            default: v = $urandom_range(0, VAL_MAX);
          endcase
          send_request(pack_req(OP_WRITE, 1'($urandom_range(0, 1)), 4'(k), POS_W'(p),
                                VAL_W'(v), POS_W'($urandom)), 1'b0, '0);
          last_p = p;
          if ($urandom_range(0, 5) != 0) p = p + $urandom_range(1, 12);
          if (p > 16'hFFFF) p = 16'hFFFF;
        end

        // start position around the envelope
        lo = (first_p > 4) ? first_p - 4 : 0;
        hi = (last_p + 2 > 16'hFFFF) ? 16'hFFFF : last_p + 2;
        if ($urandom_range(0, 7) == 0) p = $urandom_range(0, 16'hFFFF);
        else p = $urandom_range(lo, hi);
        send_request(pack_req(OP_SETPOS, 1'b0, 4'($urandom_range(0, 15)), POS_W'($urandom),
                              VAL_W'($urandom_range(0, VAL_MAX)), POS_W'(p)), 1'b0, '0);

        // ticks with the key pressed and released, some harmless noise mixed in
        key = 1'($urandom_range(0, 1));
        repeat ($urandom_range(20, 60)) begin
          if ($urandom_range(0, 9) == 0) key = ~key;
          if ($urandom_range(0, 15) == 0)
            send_request(pack_req(($urandom_range(0, 1) != 0) ? OP_UNUSED : OP_WRITE, key,
                                  4'($urandom_range(MAX_PTS, 15)), POS_W'($urandom),
                                  VAL_W'($urandom_range(0, VAL_MAX)), POS_W'($urandom)),
                         1'b0, '0);
          else
            send_request(pack_req(OP_TICK, key, 4'($urandom_range(0, 15)), POS_W'($urandom),
                                  VAL_W'($urandom_range(0, VAL_MAX)), POS_W'($urandom)),
                         1'b0, '0);
        end
      end
    end

    drain_requests();
    $display("summary: %0d requests sent, %0d tick results compared", n_requests, n_results);
    $display("summary: %0d random register setups after the directed table", n_phases);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
